@@ rtl/rc_pulse_width_capture_unit_macros.svh @@
// Assertion macros used by the pulse width capture checker.
`ifndef RC_PULSE_WIDTH_CAPTURE_UNIT_MACROS_SVH
`define RC_PULSE_WIDTH_CAPTURE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCPW_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rcpw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCPW_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rcpw assertion failed");

`endif

@@ rtl/rcpw_pkg.sv @@
// Types, constants and register codes of the RC pulse width capture unit.
package rcpw_pkg;

  localparam int unsigned NumChannels = 6;
  localparam int unsigned TimerBits   = 24;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned DivW        = 16;
  localparam int unsigned SumW        = 19;
  localparam int unsigned CountW      = 3;
  localparam int unsigned ValueW      = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 24;

  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};
  localparam logic [ValueW-1:0]    ValueMax = {ValueW{1'b1}};

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegNormLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNormHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWideLow  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWideHigh = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWideMask = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAvgMask  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegScaleDiv = 3'd6;
  localparam logic [CfgIdxW-1:0] RegAvgCount = 3'd7;

  // Register reset values
  localparam logic [TimerBits-1:0]   RstNormLow  = 24'd79998;
  localparam logic [TimerBits-1:0]   RstNormHigh = 24'd160002;
  localparam logic [TimerBits-1:0]   RstWideLow  = 24'd71998;
  localparam logic [TimerBits-1:0]   RstWideHigh = 24'd200002;
  localparam logic [NumChannels-1:0] RstWideMask = 6'd12;
  localparam logic [NumChannels-1:0] RstAvgMask  = 6'd58;
  localparam logic [DivW-1:0]        RstScaleDiv = 16'd800;
  localparam logic [CountW-1:0]      RstAvgCount = 3'd5;

  // Item actions
  localparam logic ActCapture  = 1'b0;
  localparam logic ActEvaluate = 1'b1;

  // Divider operand select
  localparam logic DivSelWidth = 1'b0;
  localparam logic DivSelAvg   = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [ChanW-1:0]     channel;
    logic [TimerBits-1:0] capture_time;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0]     out_channel;
    logic [TimerBits-1:0] pulse_width;
    logic [ValueW-1:0]    channel_value;
    logic                 width_in_window;
    logic                 value_updated;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic edge_upd;
    logic div_start;
    logic div_sel;
    logic direct_commit;
    logic avg_acc;
    logic avg_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic is_eval;
    logic in_win;
    logic avg_mode;
    logic avg_reach;
    logic div_done;
  } status_t;

endpackage

@@ rtl/rcpw_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module rcpw_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rcpw_pkg::TimerBits-1:0] dividend_i,
  input  logic [rcpw_pkg::DivW-1:0]      divisor_i,
  output logic                          done_o,
  output logic [rcpw_pkg::TimerBits-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(rcpw_pkg::TimerBits);
  localparam logic [CntW-1:0] LastStep = CntW'(rcpw_pkg::TimerBits - 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [rcpw_pkg::DivW:0]       rem_q, rem_d;
  logic [rcpw_pkg::TimerBits-1:0] dvd_q, dvd_d;
  logic [rcpw_pkg::DivW-1:0]     dsr_q, dsr_d;
  logic [rcpw_pkg::DivW:0]       rem_shift;
  logic                          q_bit;

  always_comb begin
    rem_shift = {rem_q[rcpw_pkg::DivW-1:0], dvd_q[rcpw_pkg::TimerBits-1]};
    q_bit     = (rem_shift >= {1'b0, dsr_q});
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    dsr_d     = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = q_bit ? (rem_shift - {1'b0, dsr_q}) : rem_shift;
      dvd_d = {dvd_q[rcpw_pkg::TimerBits-2:0], q_bit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ rtl/rcpw_datapath.sv @@
// Datapath: configuration, per-channel state, window check, divider and result register.
module rcpw_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rcpw_pkg::in_item_t            in_data_i,
  input  logic                          cfg_valid_i,
  input  logic [rcpw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rcpw_pkg::CfgDataW-1:0] cfg_data_i,
  input  rcpw_pkg::cmd_t                cmd_i,
  output rcpw_pkg::status_t             status_o,
  output rcpw_pkg::out_item_t           out_data_o
);

  localparam int unsigned NCh = rcpw_pkg::NumChannels;
  localparam int unsigned TW  = rcpw_pkg::TimerBits;

  // Configuration registers
  logic [TW-1:0]                    norm_lo_q, norm_hi_q, wide_lo_q, wide_hi_q;
  logic [NCh-1:0]                   wide_mask_q, avg_mask_q;
  logic [rcpw_pkg::DivW-1:0]        scale_div_q;
  logic [rcpw_pkg::CountW-1:0]      avg_count_q;

  // Per-channel state
  logic [NCh-1:0]                   phase_q;
  logic [TW-1:0]                    start_q [NCh];
  logic [TW-1:0]                    width_q [NCh];
  logic [rcpw_pkg::SumW-1:0]        sum_q   [NCh];
  logic [rcpw_pkg::CountW-1:0]      count_q [NCh];
  logic [rcpw_pkg::ValueW-1:0]      value_q [NCh];

  // Item being worked on
  logic                             act_q;
  logic [rcpw_pkg::ChanW-1:0]       ch_q;
  logic [TW-1:0]                    cap_q;
  logic                             updated_q;
  rcpw_pkg::out_item_t              out_q;

  logic                             ch_ok;
  logic [TW-1:0]                    cur_width, cur_start, new_width, win_lo, win_hi;
  logic [rcpw_pkg::SumW-1:0]        cur_sum;
  logic [rcpw_pkg::CountW-1:0]      cur_count, avg_n;
  logic [rcpw_pkg::ValueW-1:0]      cur_value, q_sat;
  logic                             wide_sel, avg_sel, in_win;
  logic                             div_done;
  logic [TW-1:0]                    div_dividend, div_quot;
  logic [rcpw_pkg::DivW-1:0]        div_divisor;

  assign ch_ok = (ch_q < rcpw_pkg::ChanW'(NCh));

  always_comb begin
    cur_width = ch_ok ? width_q[ch_q] : '0;
    cur_start = ch_ok ? start_q[ch_q] : '0;
    cur_sum   = ch_ok ? sum_q[ch_q]   : '0;
    cur_count = ch_ok ? count_q[ch_q] : '0;
    cur_value = ch_ok ? value_q[ch_q] : '0;
    wide_sel  = ch_ok && wide_mask_q[ch_q];
    avg_sel   = ch_ok && avg_mask_q[ch_q];
    win_lo    = wide_sel ? wide_lo_q : norm_lo_q;
    win_hi    = wide_sel ? wide_hi_q : norm_hi_q;
    in_win    = ch_ok && (cur_width > win_lo) && (cur_width < win_hi);
    // wrap case: timer rolled over between the start and end captures
    new_width = (cap_q > cur_start) ? (cap_q - cur_start)
                                    : TW'((rcpw_pkg::TimerMax - cur_start) + cap_q);
    avg_n     = (avg_count_q == '0) ? rcpw_pkg::CountW'(1) : avg_count_q;
    q_sat     = (|div_quot[TW-1:rcpw_pkg::ValueW]) ? rcpw_pkg::ValueMax
                                                   : div_quot[rcpw_pkg::ValueW-1:0];
    div_dividend = (cmd_i.div_sel == rcpw_pkg::DivSelAvg)
                   ? TW'(cur_sum) : cur_width;
    div_divisor  = (cmd_i.div_sel == rcpw_pkg::DivSelAvg)
                   ? rcpw_pkg::DivW'(avg_n) : scale_div_q;
  end

  rcpw_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_lo_q   <= rcpw_pkg::RstNormLow;
      norm_hi_q   <= rcpw_pkg::RstNormHigh;
      wide_lo_q   <= rcpw_pkg::RstWideLow;
      wide_hi_q   <= rcpw_pkg::RstWideHigh;
      wide_mask_q <= rcpw_pkg::RstWideMask;
      avg_mask_q  <= rcpw_pkg::RstAvgMask;
      scale_div_q <= rcpw_pkg::RstScaleDiv;
      avg_count_q <= rcpw_pkg::RstAvgCount;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rcpw_pkg::RegNormLow:  norm_lo_q   <= cfg_data_i[TW-1:0];
        rcpw_pkg::RegNormHigh: norm_hi_q   <= cfg_data_i[TW-1:0];
        rcpw_pkg::RegWideLow:  wide_lo_q   <= cfg_data_i[TW-1:0];
        rcpw_pkg::RegWideHigh: wide_hi_q   <= cfg_data_i[TW-1:0];
        rcpw_pkg::RegWideMask: wide_mask_q <= cfg_data_i[NCh-1:0];
        rcpw_pkg::RegAvgMask:  avg_mask_q  <= cfg_data_i[NCh-1:0];
        rcpw_pkg::RegScaleDiv: scale_div_q <= cfg_data_i[rcpw_pkg::DivW-1:0];
        rcpw_pkg::RegAvgCount: avg_count_q <= cfg_data_i[rcpw_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      updated_q <= 1'b0;
      for (int c = 0; c < NCh; c++) begin
        start_q[c] <= '0;
        width_q[c] <= '0;
        sum_q[c]   <= '0;
        count_q[c] <= '0;
        value_q[c] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        updated_q <= 1'b0;
      end
      if (ch_ok) begin
        if (cmd_i.edge_upd) begin
          if (!phase_q[ch_q]) begin
            start_q[ch_q] <= cap_q;
          end else begin
            width_q[ch_q] <= new_width;
          end
          phase_q[ch_q] <= ~phase_q[ch_q];
        end
        if (cmd_i.direct_commit) begin
          value_q[ch_q] <= q_sat;
          updated_q     <= 1'b1;
        end
        if (cmd_i.avg_acc) begin
          sum_q[ch_q]   <= rcpw_pkg::SumW'(cur_sum + rcpw_pkg::SumW'(q_sat));
          count_q[ch_q] <= cur_count + 1'b1;
        end
        if (cmd_i.avg_commit) begin
          value_q[ch_q] <= div_quot[rcpw_pkg::ValueW-1:0];
          sum_q[ch_q]   <= '0;
          count_q[ch_q] <= '0;
          updated_q     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_data_i.action;
      ch_q  <= in_data_i.channel;
      cap_q <= in_data_i.capture_time;
    end
    if (cmd_i.out_load) begin
      out_q.out_channel     <= ch_q;
      out_q.pulse_width     <= cur_width;
      out_q.channel_value   <= cur_value;
      out_q.width_in_window <= in_win;
      out_q.value_updated   <= updated_q;
    end
  end

  always_comb begin
    status_o.ch_ok     = ch_ok;
    status_o.is_eval   = (act_q == rcpw_pkg::ActEvaluate);
    status_o.in_win    = in_win;
    status_o.avg_mode  = avg_sel;
    status_o.avg_reach = (cur_count >= avg_n);
    status_o.div_done  = div_done;
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/rcpw_ctrl.sv @@
// Controller state machine sequencing one item at a time.
module rcpw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rcpw_pkg::status_t status_i,
  output rcpw_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StDispatch = 3'd1;
  localparam logic [2:0] StDivWidth = 3'd2;
  localparam logic [2:0] StAvgCheck = 3'd3;
  localparam logic [2:0] StDivAvg   = 3'd4;
  localparam logic [2:0] StOut      = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDispatch;
        end
      end
      StDispatch: begin
        if (!status_i.ch_ok) begin
          state_d = StOut;
        end else if (!status_i.is_eval) begin
          cmd_o.edge_upd = 1'b1;
          state_d        = StOut;
        end else if (!status_i.in_win) begin
          state_d = StOut;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = rcpw_pkg::DivSelWidth;
          state_d         = StDivWidth;
        end
      end
      StDivWidth: begin
        if (status_i.div_done) begin
          if (status_i.avg_mode) begin
            cmd_o.avg_acc = 1'b1;
            state_d       = StAvgCheck;
          end else begin
            cmd_o.direct_commit = 1'b1;
            state_d             = StOut;
          end
        end
      end
      StAvgCheck: begin
        if (status_i.avg_reach) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = rcpw_pkg::DivSelAvg;
          state_d         = StDivAvg;
        end else begin
          state_d = StOut;
        end
      end
      StDivAvg: begin
        cmd_o.div_sel = rcpw_pkg::DivSelAvg;
        if (status_i.div_done) begin
          cmd_o.avg_commit = 1'b1;
          state_d          = StOut;
        end
      end
      StOut: begin
        // wait until the result register can take this item's result
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/rc_pulse_width_capture_unit.sv @@
// Top level of the six-channel RC pulse width capture unit.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, in_data_i         | item in
//   out     | out_valid_o, out_ready_i, out_data_o      | item out
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/_data_i | register write
//
// An edge item, an item with an invalid channel or an evaluate outside the window
// goes straight to the result; a direct evaluate or an averaged sample that does not
// complete the average takes one division, and a completed average takes two. The
// shared 24-step divider (one quotient bit per cycle) sets how long an item takes.
// Reset restores register defaults and clears every channel's state at once.
// A new item is taken while a result waits; its own result then holds until
// the output register is free.
module rc_pulse_width_capture_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rcpw_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rcpw_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcpw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rcpw_pkg::CfgDataW-1:0] cfg_data_i
);

  rcpw_pkg::cmd_t    cmd;
  rcpw_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  rcpw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rcpw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/rcpw_checker.sv @@
// Port-level checker for the pulse width capture unit, bound to the top level.
`include "rc_pulse_width_capture_unit_macros.svh"

module rcpw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rcpw_pkg::out_item_t out_data_o
);

  `RCPW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `RCPW_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `RCPW_ASSERT_NOW(a_upd_in_win, clk_i, rst_ni, out_valid_o && out_data_o.value_updated, out_data_o.width_in_window)
  `RCPW_ASSERT_NOW(a_bad_chan, clk_i, rst_ni, out_valid_o && (out_data_o.out_channel == 3'd6 || out_data_o.out_channel == 3'd7), out_data_o.pulse_width == '0 && out_data_o.channel_value == '0 && !out_data_o.value_updated)

endmodule

bind rc_pulse_width_capture_unit rcpw_checker u_rcpw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ tb/rc_pulse_width_capture_unit_tb.sv @@
// Self-checking bench for the pulse width capture unit: directed and random items.
`timescale 1ns / 1ps

module rc_pulse_width_capture_unit_tb;
  import rcpw_pkg::*;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned RandPhases   = 10;
  localparam int unsigned ItemsPerPhase = 115;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned MaxChanCode  = (1 << ChanW) - 1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  rc_pulse_width_capture_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Register copy, kept in step with accepted writes
  logic [TimerBits-1:0]   norm_lo = RstNormLow;
  logic [TimerBits-1:0]   norm_hi = RstNormHigh;
  logic [TimerBits-1:0]   wide_lo = RstWideLow;
  logic [TimerBits-1:0]   wide_hi = RstWideHigh;
  logic [NumChannels-1:0] wide_mask = RstWideMask;
  logic [NumChannels-1:0] avg_mask = RstAvgMask;
  logic [DivW-1:0]        scale_div = RstScaleDiv;
  logic [CountW-1:0]      avg_count = RstAvgCount;

  // Per-channel state of the predictor
  logic                 chan_high  [NumChannels];
  logic [TimerBits-1:0] chan_start [NumChannels];
  logic [TimerBits-1:0] chan_width [NumChannels];
  logic [SumW-1:0]      chan_sum   [NumChannels];
  logic [CountW-1:0]    chan_count [NumChannels];
  logic [ValueW-1:0]    chan_value [NumChannels];

  // Edge phase as seen by the item generator
  logic gen_high [NumChannels];

  in_item_t  pending_items[$];
  out_item_t expected_readings[$];

  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned evals_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned updates_seen = 0;
  int unsigned settings_used = 0;
  int unsigned long_holds = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  int unsigned in_gap = 0;
  int unsigned in_burst = 0;
  int unsigned out_wait = 0;
  int unsigned out_burst = 0;
  int unsigned hold_left = 0;

  function automatic logic width_in_window(logic [ChanW-1:0] ch, logic [TimerBits-1:0] w);
    logic [TimerBits-1:0] lo;
    logic [TimerBits-1:0] hi;
    lo = norm_lo;
    hi = norm_hi;
    if (ch < NumChannels && wide_mask[ch]) begin
      lo = wide_lo;
      hi = wide_hi;
    end
    return (w > lo) && (w < hi);
  endfunction

  function automatic out_item_t predict_reading(in_item_t it);
    out_item_t            r;
    logic [ChanW-1:0]     ch;
    logic [TimerBits-1:0] quo;
    logic [CountW-1:0]    n;
    logic                 upd;
    ch = it.channel;
    upd = 1'b0;
    r = '0;
    r.out_channel = ch;
    if (ch >= NumChannels) return r;
    if (it.action == ActCapture) begin
      if (!chan_high[ch]) begin
        chan_start[ch] = it.capture_time;
        chan_high[ch] = 1'b1;
      end else begin
        // wrap: capture at or below start counts through the timer top
        if (it.capture_time > chan_start[ch]) chan_width[ch] = it.capture_time - chan_start[ch];
        else chan_width[ch] = TimerMax - chan_start[ch] + it.capture_time;
        chan_high[ch] = 1'b0;
      end
    end else if (width_in_window(ch, chan_width[ch])) begin
      if (scale_div == '0) quo = ValueMax;
      else quo = chan_width[ch] / scale_div;
      if (quo > ValueMax) quo = ValueMax;
      if (avg_mask[ch]) begin
        n = (avg_count == '0) ? CountW'(1) : avg_count;
        chan_sum[ch] = chan_sum[ch] + quo[ValueW-1:0];
        chan_count[ch] = chan_count[ch] + 1'b1;
        if (chan_count[ch] >= n) begin
          chan_value[ch] = chan_sum[ch] / n;
          chan_sum[ch] = '0;
          chan_count[ch] = '0;
          upd = 1'b1;
        end
      end else begin
        chan_value[ch] = quo[ValueW-1:0];
        upd = 1'b1;
      end
    end
    r.pulse_width = chan_width[ch];
    r.channel_value = chan_value[ch];
    r.width_in_window = width_in_window(ch, chan_width[ch]);
    r.value_updated = upd;
    return r;
  endfunction

  function automatic void flag_field(string field, logic [23:0] want_v, logic [23:0] got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    mismatches++;
  endfunction

  function automatic void enqueue_item(logic act, int unsigned ch, logic [TimerBits-1:0] t);
    in_item_t it;
    it.action = act;
    it.channel = ch[ChanW-1:0];
    it.capture_time = t;
    pending_items.push_back(it);
    items_queued++;
    if (act == ActCapture && ch < NumChannels) gen_high[ch] = !gen_high[ch];
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegNormLow:  norm_lo = val;
      RegNormHigh: norm_hi = val;
      RegWideLow:  wide_lo = val;
      RegWideHigh: wide_hi = val;
      RegWideMask: wide_mask = val[NumChannels-1:0];
      RegAvgMask:  avg_mask = val[NumChannels-1:0];
      RegScaleDiv: scale_div = val[DivW-1:0];
      RegAvgCount: avg_count = val[CountW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Every item gives exactly one result, so matching counters means the block is idle
  task automatic wait_idle();
    while (items_accepted != items_queued || results_seen != items_accepted) @(posedge clk_i);
  endtask

  task automatic load_random_setting(int unsigned p);
    logic [TimerBits-1:0]   lo_n, hi_n, lo_w, hi_w;
    logic [NumChannels-1:0] wm, am;
    logic [DivW-1:0]        dv;
    logic [CountW-1:0]      cnt;
    lo_n = $urandom_range(1000, 150000);
    hi_n = lo_n + $urandom_range(1000, 150000);
    lo_w = $urandom_range(1000, 150000);
    hi_w = lo_w + $urandom_range(1000, 200000);
    wm = $urandom;
    am = $urandom;
    dv = $urandom_range(256, 4000);
    cnt = $urandom_range(1, 7);
    case (p)
      1: begin dv = 16'd256; cnt = 3'd1; end
      2: begin dv = ValueMax; cnt = 3'd7; lo_n = '0; hi_n = TimerMax; end
      3: begin wm = '0; am = '0; end
      4: begin wm = '1; am = '1; lo_w = '0; hi_w = TimerMax; cnt = '0; end
      5: begin lo_n = TimerMax; hi_n = '0; dv = '0; end
      6: dv = 16'd1;
      default: ;
    endcase
    write_reg(RegNormLow, lo_n);
    write_reg(RegNormHigh, hi_n);
    write_reg(RegWideLow, lo_w);
    write_reg(RegWideHigh, hi_w);
    write_reg(RegWideMask, wm);
    write_reg(RegAvgMask, am);
    write_reg(RegScaleDiv, dv);
    write_reg(RegAvgCount, cnt);
    settings_used++;
  endtask

  // Mostly complete pulses followed by evaluates; the rest stray edges and evaluates
  task automatic queue_random_items(int unsigned n);
    int unsigned          stop_at, ch, sel, r;
    logic [TimerBits-1:0] lo, hi, st, w;
    logic [TimerBits:0]   ext;
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      sel = $urandom_range(0, 99);
      ch = $urandom_range(0, NumChannels - 1);
      if (sel < 75) begin
        if (gen_high[ch]) enqueue_item(ActCapture, ch, $urandom);
        lo = norm_lo;
        hi = norm_hi;
        if (wide_mask[ch]) begin
          lo = wide_lo;
          hi = wide_hi;
        end
        r = $urandom_range(0, 9);
        if (r < 6 && hi > lo + 1) w = $urandom_range(lo + 1, hi - 1);
        else if (r < 7) w = lo + $urandom_range(0, 2) - 1;
        else if (r < 8) w = hi + $urandom_range(0, 2) - 1;
        else w = $urandom;
        st = $urandom;
        ext = st + w;
        if (ext > TimerMax) ext = ext - TimerMax;
        enqueue_item(ActCapture, ch, st);
        enqueue_item(ActCapture, ch, ext[TimerBits-1:0]);
        repeat ($urandom_range(1, 4)) enqueue_item(ActEvaluate, ch, $urandom);
      end else if (sel < 90) begin
        enqueue_item(ActCapture, $urandom_range(0, MaxChanCode), $urandom);
      end else begin
        enqueue_item(ActEvaluate, $urandom_range(0, MaxChanCode), $urandom);
      end
    end
  endtask

  // Input side
  always @(posedge clk_i) begin
    in_item_t nxt_item;
    logic     nxt_valid;
    nxt_item = in_data_i;
    nxt_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_readings.push_back(predict_reading(in_data_i));
        items_accepted++;
        if (in_data_i.action == ActEvaluate) evals_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          nxt_item = pending_items.pop_front();
          nxt_valid = 1'b1;
          if (in_burst == 0 && $urandom_range(0, 29) == 0) in_burst = $urandom_range(20, 60);
          if (in_burst > 0) begin
            in_burst--;
            in_gap = 0;
          end else begin
            in_gap = $urandom_range(0, 10);
          end
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i <= nxt_item;
  end

  // Output side
  always @(posedge clk_i) begin
    out_item_t want;
    logic      nxt_ready;
    nxt_ready = out_ready_i;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_readings.size() == 0) begin
          $display("%0t: result with none expected, expected none, actual %p",
                   $time, out_data_o);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (out_data_o.out_channel !== want.out_channel)
            flag_field("out_channel", want.out_channel, out_data_o.out_channel);
          if (out_data_o.pulse_width !== want.pulse_width)
            flag_field("pulse_width", want.pulse_width, out_data_o.pulse_width);
          if (out_data_o.channel_value !== want.channel_value)
            flag_field("channel_value", want.channel_value, out_data_o.channel_value);
          if (out_data_o.width_in_window !== want.width_in_window)
            flag_field("width_in_window", want.width_in_window, out_data_o.width_in_window);
          if (out_data_o.value_updated !== want.value_updated)
            flag_field("value_updated", want.value_updated, out_data_o.value_updated);
          if (want.value_updated) updates_seen++;
        end
        if (out_burst == 0 && $urandom_range(0, 29) == 0) out_burst = $urandom_range(20, 60);
        if (out_burst > 0) begin
          out_burst--;
          out_wait = 0;
        end else begin
          out_wait = $urandom_range(0, 10);
        end
        // long back-pressure so the input side fills and stalls
        if (results_seen == 300 || results_seen == 900) begin
          hold_left = HoldCycles;
          long_holds++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    out_ready_i <= nxt_ready;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               expected_readings.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < NumChannels; c++) begin
      chan_high[c] = 1'b0;
      chan_start[c] = '0;
      chan_width[c] = '0;
      chan_sum[c] = '0;
      chan_count[c] = '0;
      chan_value[c] = '0;
      gen_high[c] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    settings_used++;

    // Reset settings: zero width, out-of-range channels, timer extremes and wrap,
    // window edges, a full average
    enqueue_item(ActEvaluate, 0, 24'h123456);
    enqueue_item(ActCapture, 7, 24'hABCDEF);
    enqueue_item(ActEvaluate, 6, 24'h000000);
    enqueue_item(ActCapture, 0, 24'h000000);
    enqueue_item(ActCapture, 0, 24'hFFFFFF);
    enqueue_item(ActCapture, 1, 24'hFFFFFF);
    enqueue_item(ActCapture, 1, 24'h000000);
    enqueue_item(ActCapture, 4, 24'h800000);
    enqueue_item(ActCapture, 4, 24'h800000);
    enqueue_item(ActCapture, 0, 24'd100);
    enqueue_item(ActCapture, 0, 24'd120100);
    enqueue_item(ActEvaluate, 0, 24'hFFFFFF);
    enqueue_item(ActCapture, 1, 24'hFFF000);
    enqueue_item(ActCapture, 1, 24'd95905);
    repeat (5) enqueue_item(ActEvaluate, 1, 24'h000000);
    enqueue_item(ActCapture, 2, 24'd1000);
    enqueue_item(ActCapture, 2, 24'd72999);
    enqueue_item(ActEvaluate, 2, 24'h5A5A5A);
    enqueue_item(ActCapture, 3, 24'd500);
    enqueue_item(ActCapture, 3, 24'd200501);
    enqueue_item(ActEvaluate, 3, 24'hA5A5A5);
    wait_idle();

    // Zero divisor saturates; partial averages on two channels
    write_reg(RegNormLow, '0);
    write_reg(RegNormHigh, TimerMax);
    write_reg(RegWideMask, '0);
    write_reg(RegAvgMask, '1);
    write_reg(RegScaleDiv, '0);
    write_reg(RegAvgCount, 3'd7);
    settings_used++;
    enqueue_item(ActCapture, 0, 24'd0);
    enqueue_item(ActCapture, 0, 24'd5000);
    repeat (3) enqueue_item(ActEvaluate, 0, 24'd0);
    enqueue_item(ActCapture, 5, 24'd10);
    enqueue_item(ActCapture, 5, 24'd90010);
    repeat (2) enqueue_item(ActEvaluate, 5, 24'd0);
    wait_idle();

    // Count lowered below the samples taken; channel 5 switched to direct mid-average
    write_reg(RegAvgCount, 3'd2);
    write_reg(RegAvgMask, 6'h1F);
    settings_used++;
    enqueue_item(ActEvaluate, 0, 24'd0);
    enqueue_item(ActEvaluate, 5, 24'd0);
    wait_idle();

    // Back to averaging with count zero and divisor one
    write_reg(RegAvgMask, '1);
    write_reg(RegAvgCount, '0);
    write_reg(RegScaleDiv, 16'd1);
    settings_used++;
    enqueue_item(ActEvaluate, 5, 24'd0);
    enqueue_item(ActEvaluate, 0, 24'd0);
    wait_idle();

    for (int unsigned p = 0; p < RandPhases; p++) begin
      load_random_setting(p);
      queue_random_items(ItemsPerPhase);
      wait_idle();
    end

    repeat (80) @(posedge clk_i);
    $display("Ran %0d items (%0d evaluates) under %0d register settings.", items_accepted,
             evals_accepted, settings_used);
    $display("Checked %0d results, %0d value updates, %0d long output stalls, %0d mismatches.",
             results_seen, updates_seen, long_holds, mismatches);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
